@@ src/psm_pkg.sv @@
// Shared types and constants for the permutation segment move block.
// Request and response payloads, opcodes, and the command broadcast to the cell row.
// No dependencies.
package psm_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int DATA_W  = 6;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [5:0]        element_index;
        logic [DATA_W-1:0] element_value;
        logic [5:0]        segment_end_one;
        logic [5:0]        segment_end_two;
        logic [5:0]        destination;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              moved;
        logic              range_error;
    } t_rsp;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_ROTR,
        CELL_ROTL
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [IDX_W-1:0]  sel;
        logic [DATA_W-1:0] wdata;
    } t_chain_cmd;

endpackage

@@ src/psm_cell.sv @@
// One element of the permutation vector, a cell of the rotating row.
// Takes its neighbor's value or the wrap bus during a rotation; drives its tap when selected.
// Depends on psm_pkg.
module psm_cell (
    input  logic                         i_clk,
    input  logic [psm_pkg::IDX_W-1:0]    i_pos,
    input  psm_pkg::t_chain_cmd          i_cmd,
    input  logic [psm_pkg::DATA_W-1:0]   i_left,
    input  logic [psm_pkg::DATA_W-1:0]   i_right,
    input  logic [psm_pkg::DATA_W-1:0]   i_wrap,
    output logic [psm_pkg::DATA_W-1:0]   o_val,
    output logic [psm_pkg::DATA_W-1:0]   o_tap
);

    logic [psm_pkg::DATA_W-1:0] r_val;
    logic [psm_pkg::DATA_W-1:0] n_val;
    logic                       above_lo;
    logic                       below_hi;
    logic                       at_lo;
    logic                       at_hi;

    always_comb begin
        above_lo = i_pos > i_cmd.lo;
        below_hi = i_pos < i_cmd.hi;
        at_lo    = i_pos == i_cmd.lo;
        at_hi    = i_pos == i_cmd.hi;
        n_val    = r_val;
        case (i_cmd.op)
            psm_pkg::CELL_LOAD: begin
                if (i_pos == i_cmd.sel) n_val = i_cmd.wdata;
            end
            psm_pkg::CELL_ROTR: begin
                if (at_lo) n_val = i_wrap;
                else if (above_lo && (below_hi || at_hi)) n_val = i_left;
            end
            psm_pkg::CELL_ROTL: begin
                if (at_hi) n_val = i_wrap;
                else if (below_hi && (above_lo || at_lo)) n_val = i_right;
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_tap = (i_pos == i_cmd.sel) ? r_val : '0;

endmodule

@@ src/psm_ctrl.sv @@
// Request sequencer: length register, segment checks, rotation count, response register.
// Drives the command shared by all cells and samples the OR-ed tap bus.
// Depends on psm_pkg.
module psm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [psm_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  psm_pkg::t_req               i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output psm_pkg::t_rsp               o_out_rsp,
    output psm_pkg::t_chain_cmd         o_cmd,
    input  logic [psm_pkg::DATA_W-1:0]  i_tap
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_CHECK,
        S_ROT,
        S_FIN
    } t_state;

    t_state                      r_state;
    psm_pkg::t_req               r_req;
    psm_pkg::t_rsp               r_rsp;
    logic                        r_out_valid;
    logic [psm_pkg::LEN_W-1:0]   r_len;
    logic [psm_pkg::IDX_W-1:0]   r_lo;
    logic [psm_pkg::IDX_W-1:0]   r_hi;
    logic                        r_dir_left;
    logic [psm_pkg::LEN_W-1:0]   r_cnt;

    logic [psm_pkg::LEN_W-1:0]   len_eff;
    logic [psm_pkg::IDX_W-1:0]   seg_a;
    logic [psm_pkg::IDX_W-1:0]   seg_b;
    logic [psm_pkg::IDX_W-1:0]   dest;
    logic [psm_pkg::LEN_W-1:0]   seg_len;
    logic [psm_pkg::LEN_W:0]     reach;
    logic                        err;
    logic                        noop;
    logic                        out_free;
    logic                        rsp_load;

    always_comb begin
        if (r_len == '0) begin
            len_eff = psm_pkg::LEN_W'(1);
        end else if (r_len > psm_pkg::LEN_W'(psm_pkg::MAX_LEN)) begin
            len_eff = psm_pkg::LEN_W'(psm_pkg::MAX_LEN);
        end else begin
            len_eff = r_len;
        end

        if (r_req.segment_end_one < r_req.segment_end_two) begin
            seg_a = r_req.segment_end_one;
            seg_b = r_req.segment_end_two;
        end else begin
            seg_a = r_req.segment_end_two;
            seg_b = r_req.segment_end_one;
        end
        dest    = r_req.destination;
        seg_len = {1'b0, seg_b} - {1'b0, seg_a} + psm_pkg::LEN_W'(1);
        reach   = {2'b00, dest} + {1'b0, seg_len};
        err     = ({1'b0, seg_b} >= len_eff) || (reach > {1'b0, len_eff});
        noop    = dest == seg_a;
        out_free = !r_out_valid || !i_out_stall;
        rsp_load = out_free && ((r_state == S_READ) || (r_state == S_FIN) ||
                                ((r_state == S_CHECK) && (err || noop)));

        o_cmd.op    = psm_pkg::CELL_HOLD;
        o_cmd.lo    = r_lo;
        o_cmd.hi    = r_hi;
        o_cmd.sel   = r_req.element_index;
        o_cmd.wdata = r_req.element_value;
        unique case (r_state)
            S_LOAD: o_cmd.op = psm_pkg::CELL_LOAD;
            S_ROT: begin
                if (r_dir_left) begin
                    o_cmd.op  = psm_pkg::CELL_ROTL;
                    o_cmd.sel = r_lo;
                end else begin
                    o_cmd.op  = psm_pkg::CELL_ROTR;
                    o_cmd.sel = r_hi;
                end
            end
            default: o_cmd.op = psm_pkg::CELL_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_len       <= psm_pkg::LEN_W'(psm_pkg::MAX_LEN);
        end else begin
            if (i_cfg_we) r_len <= i_cfg_wdata;
            if (rsp_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in_req;
                        case (i_in_req.operation)
                            psm_pkg::OP_LOAD: r_state <= S_LOAD;
                            psm_pkg::OP_MOVE: r_state <= S_CHECK;
                            psm_pkg::OP_READ: r_state <= S_READ;
                            default:          r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LOAD: r_state <= S_IDLE;
                S_READ: begin
                    if (out_free) begin
                        r_rsp       <= '{read_value: i_tap, moved: 1'b0, range_error: 1'b0};
                        r_state     <= S_IDLE;
                    end
                end
                S_CHECK: begin
                    if (err || noop) begin
                        if (out_free) begin
                            r_rsp       <= '{read_value: '0, moved: 1'b0, range_error: err};
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        // segment moves left: rotate [c..b] right; else rotate [a..c+seg-1] left
                        r_cnt <= seg_len;
                        if (dest < seg_a) begin
                            r_dir_left <= 1'b0;
                            r_lo       <= dest;
                            r_hi       <= seg_b;
                        end else begin
                            r_dir_left <= 1'b1;
                            r_lo       <= seg_a;
                            r_hi       <= psm_pkg::IDX_W'(reach - (psm_pkg::LEN_W + 1)'(1));
                        end
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_cnt <= r_cnt - psm_pkg::LEN_W'(1);
                    if (r_cnt == psm_pkg::LEN_W'(1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_rsp       <= '{read_value: '0, moved: 1'b1, range_error: 1'b0};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

endmodule

@@ src/permutation_segment_move.sv @@
// Top level of the permutation segment move block: sequencer plus a row of element cells.
// Depends on psm_pkg, psm_cell, psm_ctrl.
//
// The permutation lives in a row of cells, one element each. A move of a segment of length L
// rotates the covered span by one position per cycle along the cell row, L times; at full
// length the longest segment that can move has 63 elements. A new request is taken while a
// response still waits at the output. Stores start undefined; only written entries may be
// read, directly or through a move.
module permutation_segment_move (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [psm_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  psm_pkg::t_req               i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output psm_pkg::t_rsp               o_out_rsp
);

    psm_pkg::t_chain_cmd         cmd;
    logic [psm_pkg::DATA_W-1:0]  vals [psm_pkg::MAX_LEN];
    logic [psm_pkg::DATA_W-1:0]  taps [psm_pkg::MAX_LEN];
    logic [psm_pkg::DATA_W-1:0]  tap_bus;

    psm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .o_cmd       (cmd),
        .i_tap       (tap_bus)
    );

    for (genvar g = 0; g < psm_pkg::MAX_LEN; g++) begin : g_cell
        logic [psm_pkg::DATA_W-1:0] left_val;
        logic [psm_pkg::DATA_W-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = vals[g-1];
        end

        if (g == psm_pkg::MAX_LEN - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = vals[g+1];
        end

        psm_cell u_cell (
            .i_clk   (i_clk),
            .i_pos   (psm_pkg::IDX_W'(g)),
            .i_cmd   (cmd),
            .i_left  (left_val),
            .i_right (right_val),
            .i_wrap  (tap_bus),
            .o_val   (vals[g]),
            .o_tap   (taps[g])
        );
    end

    always_comb begin
        tap_bus = '0;
        for (int i = 0; i < psm_pkg::MAX_LEN; i++) begin
            tap_bus = tap_bus | taps[i];
        end
    end

endmodule
